// File: rtl/expm1n_pkg.sv
// shared constants and binary32 arithmetic functions for the expm1 pipeline
`default_nettype none

package expm1n_pkg;

    localparam int unsigned Stages = 14;

    localparam logic [31:0] MAGIC_BIAS   = 32'h49C0_0000;
    localparam logic [31:0] MAGIC_BIAS_N = 32'hC9C0_0000;
    localparam logic [31:0] LOG2E        = 32'h3FB8_AA3B;
    localparam logic [31:0] X_SAT_LIMIT  = 32'hC18A_A123;
    localparam logic [31:0] MLN2_HI      = 32'hBF31_7200;
    localparam logic [31:0] MLN2_LO      = 32'hB5BF_BE8E;
    localparam logic [31:0] COEF4        = 32'h3D2A_AC76;
    localparam logic [31:0] COEF3        = 32'h3E2A_AE10;
    localparam logic [31:0] COEF2        = 32'h3F00_0000;
    localparam logic [31:0] NEG_ONE      = 32'hBF80_0000;
    localparam logic [31:0] DEFAULT_NAN  = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    // 2^(k/8) with (k << 20) taken off
    function automatic logic [31:0] exp2_frac(input logic [2:0] k);
        logic [31:0] w;
        case (k)
            3'd0:    w = 32'h3F80_0000;
            3'd1:    w = 32'h3F7B_95C2;
            3'd2:    w = 32'h3F78_37F0;
            3'd3:    w = 32'h3F75_FED7;
            3'd4:    w = 32'h3F75_04F3;
            3'd5:    w = 32'h3F75_672A;
            3'd6:    w = 32'h3F77_44FD;
            3'd7:    w = 32'h3F7A_C0C7;
            default: w = 32'h3F80_0000;
        endcase
        return w;
    endfunction

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] c;
        logic       found;
        c     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                c     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] c;
        logic       found;
        c     = 6'd50;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && v[i]) begin
                c     = 6'(49 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    // round to nearest even and pack; sig has its leading one at bit 47
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [47:0] sig);
        logic [95:0]        wide;
        logic [47:0]        m;
        logic [5:0]         sh;
        logic signed [11:0] d;
        logic [7:0]         ef;
        logic [30:0]        base;
        logic               g;
        logic               st;
        logic               up;
        logic [31:0]        res;
        d = 12'sd1 - e;
        if (e >= 12'sd1)
            sh = 6'd0;
        else if (d > 12'sd48)
            sh = 6'd48;
        else
            sh = d[5:0];
        wide = {sig, 48'd0} >> sh;
        m    = wide[95:48];
        ef   = (e >= 12'sd1) ? (e[7:0] - 8'd1) : 8'd0;
        base = {ef, 23'd0} + {7'd0, m[47:24]};
        g    = m[23];
        st   = (|m[22:0]) | (|wide[47:0]);
        up   = g & (st | m[24]);
        base = base + {30'd0, up};
        if (e >= 12'sd255)
            res = {sgn, 31'h7F80_0000};
        else
            res = {sgn, base};
        return res;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sgn;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic signed [11:0] e;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        prod;
        logic [5:0]         lz;
        logic [31:0]        res;
        sgn  = a[31] ^ b[31];
        ea   = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
        eb   = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
        ma   = {a[30:23] != 8'd0, a[22:0]};
        mb   = {b[30:23] != 8'd0, b[22:0]};
        prod = ma * mb;
        lz   = lzc48(prod);
        e    = ea + eb - 12'sd126 - $signed({6'd0, lz});
        if (is_nan(a))
            res = a | QUIET_BIT;
        else if (is_nan(b))
            res = b | QUIET_BIT;
        else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            res = DEFAULT_NAN;
        else if (is_inf(a) || is_inf(b))
            res = {sgn, 31'h7F80_0000};
        else if (is_zero(a) || is_zero(b))
            res = {sgn, 31'd0};
        else
            res = fp_round(sgn, e, prod << lz);
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic               swap;
        logic [31:0]        l;
        logic [31:0]        s;
        logic [7:0]         el;
        logic [7:0]         es;
        logic [7:0]         d;
        logic [5:0]         sh;
        logic [49:0]        l50;
        logic [49:0]        s50;
        logic [99:0]        wide;
        logic [49:0]        sal;
        logic [49:0]        r;
        logic [49:0]        nrm;
        logic [5:0]         lz;
        logic [47:0]        sig;
        logic signed [11:0] e;
        logic [31:0]        res;
        swap = b[30:0] > a[30:0];
        l    = swap ? b : a;
        s    = swap ? a : b;
        el   = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
        es   = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
        d    = el - es;
        sh   = (d > 8'd50) ? 6'd50 : d[5:0];
        l50  = {1'b0, l[30:23] != 8'd0, l[22:0], 25'd0};
        s50  = {1'b0, s[30:23] != 8'd0, s[22:0], 25'd0};
        wide = {s50, 50'd0} >> sh;
        sal  = wide[99:50] | {49'd0, |wide[49:0]};
        r    = (a[31] ^ b[31]) ? (l50 - sal) : (l50 + sal);
        lz   = lzc50(r);
        nrm  = r << lz;
        sig  = nrm[49:2] | {47'd0, |nrm[1:0]};
        e    = $signed({4'd0, el}) + 12'sd1 - $signed({6'd0, lz});
        if (is_nan(a))
            res = a | QUIET_BIT;
        else if (is_nan(b))
            res = b | QUIET_BIT;
        else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
            res = DEFAULT_NAN;
        else if (is_inf(a))
            res = a;
        else if (is_inf(b))
            res = b;
        else if (r == 50'd0)
            res = {a[31] & b[31], 31'd0};
        else
            res = fp_round(l[31], e, sig);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/expm1_negative_f32_top.sv
// expm1 for negative binary32 arguments: 14-stage pipeline, one item per cycle unless stalled
//
// input channel: in_valid / in_stall with x_bits and last_in; an item is taken
// on a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with result_bits and last_out.
// one item enters per cycle while the pipe is not frozen by out_stall,
// each pipeline stage holding one level of binary32 multiplies or adds
// (the longest path is one multiply or add with its normalise and round).
// last_in travels alongside the data and comes out unchanged as last_out.
// while the last stage holds an item and out_stall is high the whole pipe
// freezes and in_stall rises; nothing is dropped or repeated.
// reset (rst_n low, asynchronous) clears every valid bit; the pipe is empty
// and ready for an item as soon as rst_n goes high.
// arguments at or below about -17.33 give exactly -1.0.
`default_nettype none

module expm1_negative_f32_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] x_bits,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_bits,
    output logic             last_out
);
    import expm1n_pkg::*;

    logic en;
    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] vld_next;
    logic [Stages-1:0] last_reg;

    logic [31:0] m1, n2, nm3, a1_4, a2_4, t1_5, t6;
    logic [31:0] p1_7, ts7, sm7, p2_8, p3_9, p4_10, p5_11, p6_12, p7_13, r14;

    logic [31:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [31:0] s3_reg, s4_reg, s5_reg, s6_reg;
    logic        sat3_reg, sat4_reg, sat5_reg, sat6_reg;
    logic [31:0] a2_5_reg;
    logic [31:0] t7_reg, t8_reg, t9_reg, t10_reg;
    logic [31:0] ts8_reg, ts9_reg, ts10_reg, ts11_reg, ts12_reg;
    logic [31:0] sm8_reg, sm9_reg, sm10_reg, sm11_reg, sm12_reg, sm13_reg;

    logic [31:0] s3_next;
    logic        sat3_next;
    logic [31:0] t_eff;
    logic [31:0] s_eff;

    assign en       = !(vld_reg[Stages-1] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[Stages-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // scale from the biased value, wrapping exponent add
    assign s3_next   = exp2_frac(n2[2:0]) + {n2[11:0], 20'd0};
    assign sat3_next = x2_reg[31] && !is_nan(x2_reg) && (x2_reg[30:0] >= X_SAT_LIMIT[30:0]);
    assign t_eff     = sat6_reg ? 32'd0 : t6;
    assign s_eff     = sat6_reg ? 32'd0 : s6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[Stages-2:0], last_in};
            x1_reg   <= x_bits;
            x2_reg   <= x1_reg;
            x3_reg   <= x2_reg;
            x4_reg   <= x3_reg;
            s3_reg   <= s3_next;
            s4_reg   <= s3_reg;
            s5_reg   <= s4_reg;
            s6_reg   <= s5_reg;
            sat3_reg <= sat3_next;
            sat4_reg <= sat3_reg;
            sat5_reg <= sat4_reg;
            sat6_reg <= sat5_reg;
            a2_5_reg <= a2_4;
            t7_reg   <= t_eff;
            t8_reg   <= t7_reg;
            t9_reg   <= t8_reg;
            t10_reg  <= t9_reg;
            ts8_reg  <= ts7;
            ts9_reg  <= ts8_reg;
            ts10_reg <= ts9_reg;
            ts11_reg <= ts10_reg;
            ts12_reg <= ts11_reg;
            sm8_reg  <= sm7;
            sm9_reg  <= sm8_reg;
            sm10_reg <= sm9_reg;
            sm11_reg <= sm10_reg;
            sm12_reg <= sm11_reg;
            sm13_reg <= sm12_reg;
        end
    end

    // range reduction
    expm1n_fmul u_m1  (.clk(clk), .en(en), .a(x_bits), .b(LOG2E),        .y(m1));
    expm1n_fadd u_n2  (.clk(clk), .en(en), .a(m1),     .b(MAGIC_BIAS),   .y(n2));
    expm1n_fadd u_nm3 (.clk(clk), .en(en), .a(n2),     .b(MAGIC_BIAS_N), .y(nm3));
    expm1n_fmul u_a1  (.clk(clk), .en(en), .a(nm3),    .b(MLN2_HI),      .y(a1_4));
    expm1n_fmul u_a2  (.clk(clk), .en(en), .a(nm3),    .b(MLN2_LO),      .y(a2_4));
    expm1n_fadd u_t1  (.clk(clk), .en(en), .a(a1_4),   .b(x4_reg),       .y(t1_5));
    expm1n_fadd u_t6  (.clk(clk), .en(en), .a(a2_5_reg), .b(t1_5),       .y(t6));

    // polynomial and reconstruction
    expm1n_fmul u_p1  (.clk(clk), .en(en), .a(COEF4),  .b(t_eff),        .y(p1_7));
    expm1n_fmul u_ts  (.clk(clk), .en(en), .a(t_eff),  .b(s_eff),        .y(ts7));
    expm1n_fadd u_sm  (.clk(clk), .en(en), .a(s_eff),  .b(NEG_ONE),      .y(sm7));
    expm1n_fadd u_p2  (.clk(clk), .en(en), .a(p1_7),   .b(COEF3),        .y(p2_8));
    expm1n_fmul u_p3  (.clk(clk), .en(en), .a(p2_8),   .b(t8_reg),       .y(p3_9));
    expm1n_fadd u_p4  (.clk(clk), .en(en), .a(p3_9),   .b(COEF2),        .y(p4_10));
    expm1n_fmul u_p5  (.clk(clk), .en(en), .a(p4_10),  .b(t10_reg),      .y(p5_11));
    expm1n_fmul u_p6  (.clk(clk), .en(en), .a(p5_11),  .b(ts11_reg),     .y(p6_12));
    expm1n_fadd u_p7  (.clk(clk), .en(en), .a(p6_12),  .b(ts12_reg),     .y(p7_13));
    expm1n_fadd u_r   (.clk(clk), .en(en), .a(p7_13),  .b(sm13_reg),     .y(r14));

    assign out_valid   = vld_reg[Stages-1];
    assign result_bits = r14;
    assign last_out    = last_reg[Stages-1];

endmodule

`default_nettype wire

// File: rtl/expm1n_fmul.sv
// registered binary32 multiplier stage, round to nearest even
`default_nettype none

module expm1n_fmul (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);
    import expm1n_pkg::*;

    logic [31:0] y_reg;
    logic [31:0] y_next;

    assign y_next = fp_mul(a, b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// File: rtl/expm1n_fadd.sv
// registered binary32 adder stage, round to nearest even
`default_nettype none

module expm1n_fadd (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);
    import expm1n_pkg::*;

    logic [31:0] y_reg;
    logic [31:0] y_next;

    assign y_next = fp_add(a, b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire
